// ===== hdl/grf_pkg.sv =====
// Package for the greedy repeat folding block: shared types and constants.
// Depends on nothing; every other file imports it.
`default_nettype none
package grf_pkg;
   localparam int WORD_W  = 32;
   localparam int LIMIT_W = 6;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd32;

   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic              last;
   } item_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOOP,
      ST_SKIP_CMP,
      ST_DEC_TEST,
      ST_DEC_CMP,
      ST_EMIT_RD,
      ST_EMIT_WR,
      ST_PASS_RD,
      ST_PASS_WR,
      ST_FINISH
   } state_type;
endpackage
`default_nettype wire

// ===== hdl/grf_front.sv =====
// Front queue of the folding block: accepts input words into a two-entry FIFO.
// Depends on grf_pkg for the item type.
`default_nettype none
module grf_front
   import grf_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [WORD_W-1:0] req_tdata,
   input  wire logic              req_tlast,
   output logic                   q_valid,
   output item_type               q_item,
   input  wire logic              q_pop
);
   item_type   slot_ff [2];
   item_type   slot_in [2];
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid & req_tready;
   assign q_valid    = (count_ff != 2'd0);
   assign pop        = q_pop & q_valid;
   assign q_item     = slot_ff[0];

   always_comb begin
      slot_in  = slot_ff;
      count_in = count_ff;
      if (pop) begin
         slot_in[0] = slot_ff[1];
      end
      if (push) begin
         if ((count_ff == 2'd0) || (pop && count_ff == 2'd1)) begin
            slot_in[0] = '{word: req_tdata, last: req_tlast};
         end else begin
            slot_in[pop ? 0 : 1] = '{word: req_tdata, last: req_tlast};
         end
      end
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end
endmodule
`default_nettype wire

// ===== hdl/grf_engine.sv =====
// Back end of the folding block: lookahead memory, window search and output register.
// Depends on grf_pkg for the item type, state type and constants.
`default_nettype none
module grf_engine
   import grf_pkg::*;
#(
   parameter int MAX_WINDOW      = 32,
   parameter int LOOKAHEAD_DEPTH = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_wen,
   input  wire logic [LIMIT_W-1:0] csr_wdata,
   input  wire logic               q_valid,
   input  item_type                q_item,
   output logic                    q_pop,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [WORD_W-1:0]       rsp_tdata,
   output logic                    rsp_tlast
);
   localparam int AW = (LOOKAHEAD_DEPTH > 1) ? $clog2(LOOKAHEAD_DEPTH) : 1;
   localparam int FW = $clog2(LOOKAHEAD_DEPTH + 1);
   localparam int SW = $clog2(MAX_WINDOW + 1);
   localparam int WW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam logic [FW:0] DEPTH_W = (FW+1)'(LOOKAHEAD_DEPTH);
   localparam logic [7:0]  MAXW_8  = 8'(MAX_WINDOW);
   localparam logic [7:0]  HALF_8  = 8'(LOOKAHEAD_DEPTH / 2);

   function automatic logic [AW-1:0] wrap(input logic [FW:0] x);
      logic [FW:0] y;
      begin
         y = (x >= DEPTH_W) ? (x - DEPTH_W) : x;
         return y[AW-1:0];
      end
   endfunction

   logic [WORD_W-1:0] la_mem [LOOKAHEAD_DEPTH];
   logic [WORD_W-1:0] rep_mem [MAX_WINDOW];
   logic [WORD_W-1:0] rd_a_ff, rd_b_ff, rep_rd_ff;

   state_type         state_ff, state_in;
   logic [AW-1:0]     head_ff, head_in;
   logic [FW-1:0]     fill_ff, fill_in;
   logic              skip_ff, skip_in;
   logic [SW-1:0]     bl_ff, bl_in;
   logic [SW-1:0]     off_ff, off_in;
   logic [SW-1:0]     s_ff, s_in;
   logic [SW-1:0]     i_ff, i_in;
   logic              end_ff, end_in;
   logic [WORD_W-1:0] held_ff, held_in;
   logic              held_v_ff, held_v_in;
   logic [LIMIT_W-1:0] limit_ff;
   logic              ov_ff, ov_in;
   logic [WORD_W-1:0] od_ff, od_in;
   logic              ol_ff, ol_in;

   logic              rd_en, rep_rd_en, la_we, rep_we;
   logic [AW-1:0]     ra_addr, rb_addr, wa_addr;
   logic [7:0]        lim8;
   logic [SW-1:0]     largest;
   logic              out_free;
   logic [FW:0]       fill_x, two_s, two_lg;

   always_comb begin
      lim8 = {2'b00, limit_ff};
      if (lim8 > MAXW_8) lim8 = MAXW_8;
      if (lim8 < 8'd1) lim8 = 8'd1;
      if ((lim8 - 8'd1) > HALF_8) lim8 = HALF_8 + 8'd1;
      lim8 = lim8 - 8'd1;
      largest = lim8[SW-1:0];
   end

   assign out_free = !ov_ff || rsp_tready;
   assign fill_x   = {1'b0, fill_ff};
   assign two_s    = (FW+1)'({s_ff, 1'b0});
   assign two_lg   = (FW+1)'({largest, 1'b0});
   assign wa_addr  = wrap({1'b0, head_ff} + fill_x);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (q_valid) state_in = ST_LOOP;
         ST_LOOP: begin
            if (skip_ff) begin
               if (bl_ff == '0 || off_ff == bl_ff) state_in = ST_LOOP;
               else if ((FW+1)'(off_ff) < fill_x) state_in = ST_SKIP_CMP;
               else if (end_ff) state_in = ST_LOOP;
               else state_in = ST_FINISH;
            end else if (fill_ff == '0) begin
               state_in = ST_FINISH;
            end else if (fill_x >= two_lg || end_ff) begin
               state_in = ST_DEC_TEST;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_SKIP_CMP: state_in = ST_LOOP;
         ST_DEC_TEST: begin
            if (s_ff <= largest && two_s <= fill_x) state_in = ST_DEC_CMP;
            else state_in = ST_PASS_RD;
         end
         ST_DEC_CMP: begin
            if (rd_a_ff == rd_b_ff && i_ff == s_ff - SW'(1)) state_in = ST_EMIT_RD;
            else state_in = ST_DEC_TEST;
         end
         ST_EMIT_RD:  state_in = ST_EMIT_WR;
         ST_EMIT_WR: begin
            if (!held_v_ff || out_free) begin
               state_in = (i_ff == s_ff - SW'(1)) ? ST_LOOP : ST_EMIT_RD;
            end
         end
         ST_PASS_RD:  state_in = ST_PASS_WR;
         ST_PASS_WR:  if (!held_v_ff || out_free) state_in = ST_LOOP;
         ST_FINISH:   if (!(end_ff && held_v_ff && !out_free)) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      head_in   = head_ff;
      fill_in   = fill_ff;
      skip_in   = skip_ff;
      bl_in     = bl_ff;
      off_in    = off_ff;
      s_in      = s_ff;
      i_in      = i_ff;
      end_in    = end_ff;
      held_in   = held_ff;
      held_v_in = held_v_ff;
      ov_in     = ov_ff && !rsp_tready;
      od_in     = od_ff;
      ol_in     = ol_ff;
      q_pop     = 1'b0;
      la_we     = 1'b0;
      rep_we    = 1'b0;
      rd_en     = 1'b0;
      rep_rd_en = 1'b0;
      ra_addr   = head_ff;
      rb_addr   = head_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               end_in = q_item.last;
               if (fill_x < DEPTH_W) begin
                  la_we   = 1'b1;
                  fill_in = fill_ff + FW'(1);
               end
            end
         end
         ST_LOOP: begin
            if (skip_ff) begin
               if (bl_ff == '0) begin
                  skip_in = 1'b0;
                  off_in  = '0;
               end else if (off_ff == bl_ff) begin
                  head_in = wrap({1'b0, head_ff} + (FW+1)'(bl_ff));
                  fill_in = fill_ff - FW'(bl_ff);
                  off_in  = '0;
               end else if ((FW+1)'(off_ff) < fill_x) begin
                  rd_en     = 1'b1;
                  rep_rd_en = 1'b1;
                  ra_addr   = wrap({1'b0, head_ff} + (FW+1)'(off_ff));
               end else if (end_ff) begin
                  skip_in = 1'b0;
                  off_in  = '0;
               end
            end else if (fill_ff != '0 && (fill_x >= two_lg || end_ff)) begin
               s_in = SW'(1);
               i_in = '0;
            end
         end
         ST_SKIP_CMP: begin
            if (rd_a_ff == rep_rd_ff) begin
               off_in = off_ff + SW'(1);
            end else begin
               skip_in = 1'b0;
               off_in  = '0;
            end
         end
         ST_DEC_TEST: begin
            rd_en   = 1'b1;
            ra_addr = wrap({1'b0, head_ff} + (FW+1)'(i_ff));
            rb_addr = wrap({1'b0, head_ff} + (FW+1)'(s_ff) + (FW+1)'(i_ff));
         end
         ST_DEC_CMP: begin
            if (rd_a_ff == rd_b_ff) begin
               if (i_ff == s_ff - SW'(1)) i_in = '0;
               else i_in = i_ff + SW'(1);
            end else begin
               s_in = s_ff + SW'(1);
               i_in = '0;
            end
         end
         ST_EMIT_RD: begin
            rd_en   = 1'b1;
            ra_addr = wrap({1'b0, head_ff} + (FW+1)'(i_ff));
         end
         ST_EMIT_WR: begin
            if (!held_v_ff || out_free) begin
               if (held_v_ff) begin
                  ov_in = 1'b1;
                  od_in = held_ff;
                  ol_in = 1'b0;
               end
               held_in   = rd_a_ff;
               held_v_in = 1'b1;
               rep_we    = 1'b1;
               if (i_ff == s_ff - SW'(1)) begin
                  head_in = wrap({1'b0, head_ff} + two_s);
                  fill_in = fill_ff - two_s[FW-1:0];
                  skip_in = 1'b1;
                  off_in  = '0;
                  bl_in   = s_ff;
                  s_in    = SW'(1);
                  i_in    = '0;
               end else begin
                  i_in = i_ff + SW'(1);
               end
            end
         end
         ST_PASS_RD: begin
            rd_en   = 1'b1;
            ra_addr = head_ff;
         end
         ST_PASS_WR: begin
            if (!held_v_ff || out_free) begin
               if (held_v_ff) begin
                  ov_in = 1'b1;
                  od_in = held_ff;
                  ol_in = 1'b0;
               end
               held_in   = rd_a_ff;
               held_v_in = 1'b1;
               head_in   = wrap({1'b0, head_ff} + (FW+1)'(1));
               fill_in   = fill_ff - FW'(1);
               s_in      = SW'(1);
            end
         end
         ST_FINISH: begin
            if (end_ff && !(held_v_ff && !out_free)) begin
               if (held_v_ff) begin
                  ov_in = 1'b1;
                  od_in = held_ff;
                  ol_in = 1'b1;
               end
               held_v_in = 1'b0;
               skip_in   = 1'b0;
               off_in    = '0;
               fill_in   = '0;
               s_in      = SW'(1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (la_we) la_mem[wa_addr] <= q_item.word;
      if (rd_en) begin
         rd_a_ff <= la_mem[ra_addr];
         rd_b_ff <= la_mem[rb_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (rep_we) rep_mem[i_ff[WW-1:0]] <= rd_a_ff;
      if (rep_rd_en) rep_rd_ff <= rep_mem[off_ff[WW-1:0]];
   end

   always_ff @(posedge clock) begin
      i_ff    <= i_in;
      end_ff  <= end_in;
      held_ff <= held_in;
      od_ff   <= od_in;
      ol_ff   <= ol_in;
      if (reset) begin
         state_ff  <= ST_IDLE;
         head_ff   <= '0;
         fill_ff   <= '0;
         skip_ff   <= 1'b0;
         held_v_ff <= 1'b0;
         ov_ff     <= 1'b0;
         limit_ff  <= LIMIT_RESET;
         bl_ff     <= '0;
         off_ff    <= '0;
         s_ff      <= SW'(1);
      end else begin
         state_ff  <= state_in;
         head_ff   <= head_in;
         fill_ff   <= fill_in;
         skip_ff   <= skip_in;
         held_v_ff <= held_v_in;
         ov_ff     <= ov_in;
         bl_ff     <= bl_in;
         off_ff    <= off_in;
         s_ff      <= s_in;
         if (csr_wen) limit_ff <= csr_wdata;
      end
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = od_ff;
   assign rsp_tlast  = ol_ff;
endmodule
`default_nettype wire

// ===== hdl/greedy_repeat_folding.sv =====
// Top level of the greedy repeat folding block: front queue and folding engine.
// Depends on grf_pkg, grf_front and grf_engine.
//
// The block folds each chunk of 32-bit words on its own: at each position the
// window sizes one up to the limit minus one (at most MAX_WINDOW minus one) are
// tried, and the first block that is repeated straight after is emitted once
// with all whole repeats dropped. The search runs one compare at a time through
// the two read ports of the lookahead memory: each word pair is read in
// ST_DEC_TEST and compared in ST_DEC_CMP, and each emitted word passes
// ST_EMIT_RD and ST_EMIT_WR. A two-entry queue takes new words while the engine
// works, and the output register holds one result.
`default_nettype none
module greedy_repeat_folding
   import grf_pkg::*;
#(
   parameter int MAX_WINDOW      = 32,
   parameter int LOOKAHEAD_DEPTH = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_wen,
   input  wire logic [LIMIT_W-1:0] csr_wdata,   // window_limit
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [WORD_W-1:0]  req_tdata,   // trace_word
   input  wire logic               req_tlast,   // chunk_end
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [WORD_W-1:0]       rsp_tdata,   // folded_word
   output logic                    rsp_tlast    // chunk_done
);
   logic     q_valid, q_pop;
   item_type q_item;

   grf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   grf_engine #(
      .MAX_WINDOW      (MAX_WINDOW),
      .LOOKAHEAD_DEPTH (LOOKAHEAD_DEPTH)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );
endmodule
`default_nettype wire

// ===== hdl/grf_checker.sv =====
// Port checker for the greedy repeat folding block, bound to its top level.
// Depends on grf_pkg for the word width.
`default_nettype none
module grf_checker
   import grf_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_tready,
   input wire logic              rsp_tvalid,
   input wire logic              rsp_tready,
   input wire logic [WORD_W-1:0] rsp_tdata,
   input wire logic              rsp_tlast
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result word withdrawn while stalled");
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result word changed while stalled");
   a_reset_out: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");
   a_reset_in: assert property (@(posedge clock) reset |=> req_tready)
      else $error("input not ready after reset");
endmodule

bind greedy_repeat_folding grf_checker u_grf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire

// ===== verif/greedy_repeat_folding_check.sv =====
// Checker for the greedy repeat folding block: watches both stream channels,
// predicts the folded words of every chunk and compares them in order.
// Depends on grf_pkg for the word and limit widths.
module greedy_repeat_folding_check
   import grf_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_wen,
   input  wire logic [LIMIT_W-1:0] csr_wdata,
   input  wire logic               req_tvalid,
   input  wire logic               req_tready,
   input  wire logic [WORD_W-1:0]  req_tdata,
   input  wire logic               req_tlast,
   input  wire logic               rsp_tvalid,
   input  wire logic               rsp_tready,
   input  wire logic [WORD_W-1:0]  rsp_tdata,
   input  wire logic               rsp_tlast,
   output int                      fail_count,
   output int                      pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_WIN = 32;
   localparam int DEPTH   = 64;

   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic              done;
   } folded_type;

   folded_type        folded_queue[$];
   logic [WORD_W-1:0] window[DEPTH];
   logic [WORD_W-1:0] pattern[MAX_WIN];
   int                fill;
   int                pattern_len;
   int                matched;
   bit                skipping;
   logic [WORD_W-1:0] held;
   bit                held_ok;
   logic [LIMIT_W-1:0] limit;

   assign pending_count = folded_queue.size();

   task automatic report(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      fail_count++;
   endtask

   function automatic int largest_size();
      int l;
      l = limit;
      if (l > MAX_WIN) l = MAX_WIN;
      if (l < 1) l = 1;
      if (l - 1 > DEPTH / 2) l = DEPTH / 2 + 1;
      return l - 1;
   endfunction

   task automatic push_word(input logic [WORD_W-1:0] w);
      if (held_ok) folded_queue.push_back('{held, 1'b0});
      held = w;
      held_ok = 1;
   endtask

   task automatic shift_out(input int n);
      if (n > fill) n = fill;
      for (int i = 0; i < fill - n; i++) window[i] = window[i + n];
      fill -= n;
   endtask

   task automatic decide();
      int  sizes;
      bit  hit;
      sizes = largest_size();
      for (int s = 1; s <= sizes && 2 * s <= fill; s++) begin
         hit = 1;
         for (int i = 0; i < s; i++)
            if (window[i] != window[s + i]) hit = 0;
         if (hit) begin
            for (int i = 0; i < s; i++) begin
               pattern[i] = window[i];
               push_word(window[i]);
            end
            pattern_len = s;
            shift_out(2 * s);
            skipping = 1;
            matched = 0;
            return;
         end
      end
      push_word(window[0]);
      shift_out(1);
   endtask

   task automatic fold_word(input logic [WORD_W-1:0] w, input bit last);
      if (fill < DEPTH) window[fill++] = w;
      forever begin
         if (skipping) begin
            while (matched < pattern_len && matched < fill &&
                   window[matched] == pattern[matched]) matched++;
            if (matched == pattern_len) begin
               shift_out(pattern_len);
               matched = 0;
               continue;
            end
            if (matched < fill || last) begin
               skipping = 0;
               matched = 0;
               continue;
            end
            break;
         end
         if (fill == 0) break;
         if (fill >= 2 * largest_size() || last) begin
            decide();
            continue;
         end
         break;
      end
      if (last) begin
         if (held_ok) folded_queue.push_back('{held, 1'b1});
         held_ok = 0;
         skipping = 0;
         matched = 0;
         fill = 0;
      end
   endtask

   always @(posedge clock) begin
      folded_type exp;
      if (reset) begin
         folded_queue.delete();
         fill = 0;
         skipping = 0;
         matched = 0;
         pattern_len = 0;
         held_ok = 0;
         limit = LIMIT_RESET;
         fail_count = 0;
      end else begin
         if (csr_wen) limit = csr_wdata;
         if (req_tvalid && req_tready) fold_word(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (folded_queue.size() == 0) begin
               report($sformatf("unexpected word %h", rsp_tdata));
            end else begin
               exp = folded_queue.pop_front();
               if (rsp_tdata !== exp.word)
                  report($sformatf("folded_word %h, wanted %h", rsp_tdata, exp.word));
               if (rsp_tlast !== exp.done)
                  report($sformatf("chunk_done %b, wanted %b", rsp_tlast, exp.done));
            end
         end
      end
   end
endmodule

// ===== verif/greedy_repeat_folding_test.sv =====
// Testbench top for the greedy repeat folding block: drives chunks of words,
// random stalls and limit settings; the checker module judges the results.
// Depends on grf_pkg, greedy_repeat_folding and greedy_repeat_folding_check.
module greedy_repeat_folding_test;
   import grf_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 20000;

   logic               clock = 0;
   logic               reset = 1;
   logic               csr_wen = 0;
   logic [LIMIT_W-1:0] csr_wdata = '0;
   logic               req_tvalid = 0;
   logic               req_tready;
   logic [WORD_W-1:0]  req_tdata = '0;
   logic               req_tlast = 0;
   logic               rsp_tvalid;
   logic               rsp_tready = 0;
   logic [WORD_W-1:0]  rsp_tdata;
   logic               rsp_tlast;
   int                 fail_count;
   int                 pending_count;
   int                 idle_cycles = 0;
   int                 hold_off = 0;
   bit                 stim_done = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   greedy_repeat_folding i_dut (
      .clock, .reset, .csr_wen, .csr_wdata,
      .req_tvalid, .req_tready, .req_tdata, .req_tlast,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast
   );

   greedy_repeat_folding_check i_check (.*);

   // The receiver draws a stall per word; hold_off forces a long stretch.
   always @(posedge clock) begin
      int wait_cycles;
      if (!reset) begin
         if (hold_off > 0) begin
            rsp_tready <= 0;
            hold_off--;
         end else if (!rsp_tready || rsp_tvalid) begin
            wait_cycles = $urandom_range(0, 6);
            if ($urandom_range(0, 3) == 0) wait_cycles = 0;
            rsp_tready <= (wait_cycles == 0) || ($urandom_range(0, wait_cycles) == 0);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("[greedy_repeat_folding] ERROR");
            $finish;
         end
      end
   end

   // The valid stays high after the accepting edge; a gap in the next call, or drain,
   // takes it down, so that back-to-back words need no second assignment.
   task automatic send_word(input logic [WORD_W-1:0] w, input bit last, input bit gaps);
      int gap;
      gap = gaps ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= w;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (pending_count != 0) @(posedge clock);
      repeat (2500) @(posedge clock);
   endtask

   task automatic set_limit(input logic [LIMIT_W-1:0] v);
      drain();
      csr_wen   <= 1;
      csr_wdata <= v;
      @(posedge clock);
      csr_wen <= 0;
   endtask

   // A chunk built from repeated blocks with noise, so that folds happen.
   task automatic send_chunk(input int len, input bit gaps);
      logic [WORD_W-1:0] pat[32];
      logic [WORD_W-1:0] w;
      int plen, pos, reps;
      plen = $urandom_range(1, 8);
      for (int i = 0; i < plen; i++)
         pat[i] = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3);
      pos = 0;
      while (pos < len) begin
         reps = $urandom_range(0, 4);
         for (int r = 0; r < reps && pos < len; r++)
            for (int i = 0; i < plen && pos < len; i++) begin
               w = pat[i];
               if ($urandom_range(0, 19) == 0) w = $urandom;
               send_word(w, pos == len - 1, gaps);
               pos++;
            end
         if (pos < len) begin
            send_word($urandom, pos == len - 1, gaps);
            pos++;
         end
      end
   endtask

   initial begin
      int count;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // Directed: single-word chunk, extremes, one-word repeat, cut-short repeat.
      send_word(32'h0, 1, 0);
      send_word(32'hFFFF_FFFF, 1, 0);
      send_word(32'hFFFF_FFFF, 0, 0);
      send_word(32'hFFFF_FFFF, 0, 0);
      send_word(32'hFFFF_FFFF, 1, 0);
      send_word(32'h1, 0, 0);
      send_word(32'h2, 0, 0);
      send_word(32'h1, 0, 0);
      send_word(32'h2, 0, 0);
      send_word(32'h1, 1, 0);
      set_limit(6'd0);
      send_word(32'h5, 0, 0);
      send_word(32'h5, 1, 0);
      set_limit(6'd1);
      send_word(32'h7, 0, 0);
      send_word(32'h7, 1, 0);
      set_limit(6'd2);
      send_word(32'hA5A5_5A5A, 0, 0);
      send_word(32'hA5A5_5A5A, 0, 0);
      send_word(32'h3, 1, 0);
      set_limit(6'd63);
      send_chunk(6, 0);
      // Long receiver stall while words keep coming.
      hold_off = 400;
      send_chunk(20, 0);
      set_limit(6'd32);
      count = 0;
      while (count < 180) begin
         int len;
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 70) : $urandom_range(1, 14);
         send_chunk(len, $urandom_range(0, 3) != 0);
         count += len;
         if ($urandom_range(0, 5) == 0)
            set_limit($urandom_range(0, 3) == 0 ? $urandom_range(0, 63)
                                                : $urandom_range(2, 32));
      end
      drain();
      if (fail_count == 0 && pending_count == 0) begin
         $display("[greedy_repeat_folding] OK");
      end else begin
         $display("[greedy_repeat_folding] ERROR");
      end
      $finish;
   end
endmodule
